// ===== design/nos_pkg.sv =====
package nos_pkg;

    // Default number of pending note-off slots
    localparam int PENDING_DEPTH_DEF = 16;

    // Most scheduled note-offs released by one tick
    localparam int MAX_OUT = 16;
    localparam int EMIT_W  = $clog2(MAX_OUT + 1);

    localparam int DURATION_W = 24;
    localparam logic DEF_ENABLED = 1'b1;
    localparam logic [DURATION_W-1:0] DEF_DURATION = 24'd250;

    // Input opcodes
    typedef enum logic {
        OP_NOTE = 1'b0,
        OP_TICK = 1'b1
    } nos_op_t;

    // Configuration register indexes
    typedef enum logic {
        REG_ENABLED = 1'b0,
        REG_SUSTAIN = 1'b1
    } nos_reg_t;

    typedef struct packed {
        nos_op_t     opcode;
        logic [6:0]  pitch;
        logic [6:0]  velocity;
        logic [5:0]  voice;
        logic [31:0] stamp;
    } nos_in_t;

    typedef struct packed {
        logic [6:0]  out_pitch;
        logic [6:0]  out_velocity;
        logic [5:0]  out_voice;
        logic [31:0] out_stamp;
        logic        is_last;
        logic        dropped;
    } nos_out_t;

    typedef struct packed {
        nos_reg_t                index;
        logic [DURATION_W-1:0]   value;
    } nos_cfg_t;

    // One pending note-off
    typedef struct packed {
        logic [6:0]  pitch;
        logic [5:0]  voice;
        logic [31:0] due;
    } nos_slot_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // latch the input word
        logic rd_first;  // restart scan at slot zero
        logic rd_next;   // read the following slot
        logic upd;       // refresh the matched slot
        logic append;    // store a new slot at the end
        logic set_drop;  // flag a note-on that found the table full
        logic keep;      // compact a surviving slot
        logic emit;      // take a due slot
        logic flush;     // send the last held slot
        logic send;      // send the passed-through note
        logic commit;    // set fill count to the compacted size
    } nos_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_tick;
        logic enabled;
        logic vel_zero;
        logic count_zero;
        logic full;
        logic last_slot;
        logic pitch_match;
        logic due_hit;
        logic hold_valid;
        logic out_free;
    } nos_status_t;

endpackage

// ===== design/nos_stream_if.sv =====
interface nos_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/note_off_scheduler.sv =====
// Note-off scheduler. Every note-on is passed through at once and a velocity-zero
// note-off is scheduled sustain_duration time units later (saturating at the top of
// the 32-bit range); a repeated pitch refreshes its pending entry in place. Incoming
// note-offs are swallowed while enabled; when disabled, note events pass unchanged.
// A tick releases, in insertion order, up to 16 pending note-offs whose due time is
// below its stamp, the final word of an item carrying is_last. One item is handled
// at a time, and the pending entries are scanned one per cycle through the single
// read port of the slot memory unless a busy output register stalls a tick's scan.
// Input is accepted while the previous result still waits in the output register.
module note_off_scheduler import nos_pkg::*; #(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    nos_stream_if.sink   notes,
    nos_stream_if.source results,
    nos_stream_if.sink   cfg
);

    nos_cmd_t    cmd;
    nos_status_t status;
    logic        in_ready;

    assign notes.ready = in_ready;

    nos_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (notes.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    nos_datapath #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (notes.data),
        .cmd     (cmd),
        .status  (status),
        .results (results),
        .cfg     (cfg)
    );

endmodule

// ===== design/nos_ram.sv =====
module nos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/nos_ctrl.sv =====
module nos_ctrl import nos_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  nos_status_t status,
    output nos_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_NOTE,
        S_APPEND,
        S_SEND,
        S_TICK,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Sequence the scan and the output
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                priority if (status.is_tick)
                begin
                    if (status.count_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_first = 1'b1;
                        state_next   = S_TICK;
                    end
                end
                else if (!status.enabled)
                begin
                    state_next = S_SEND;
                end
                else if (status.vel_zero)
                begin
                    state_next = S_IDLE;
                end
                else if (status.count_zero)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    cmd.rd_first = 1'b1;
                    state_next   = S_NOTE;
                end
            end
            S_NOTE:
            begin
                priority if (status.pitch_match)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_SEND;
                end
                else if (!status.last_slot)
                begin
                    cmd.rd_next = 1'b1;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                if (status.full)
                begin
                    cmd.set_drop = 1'b1;
                end
                else
                begin
                    cmd.append = 1'b1;
                end
                state_next = S_SEND;
            end
            S_SEND:
            begin
                if (status.out_free)
                begin
                    cmd.send   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                // Stall only when a due slot finds the hold and output both busy
                if (!status.due_hit || !status.hold_valid || status.out_free)
                begin
                    cmd.emit = status.due_hit;
                    cmd.keep = !status.due_hit;
                    if (status.last_slot)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                cmd.commit = 1'b1;
                priority if (!status.hold_valid)
                begin
                    state_next = S_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/nos_datapath.sv =====
module nos_datapath import nos_pkg::*; #(
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nos_in_t           in_word,
    input  nos_cmd_t          cmd,
    output nos_status_t       status,
    nos_stream_if.source      results,
    nos_stream_if.sink        cfg
);

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int SLOT_W = $bits(nos_slot_t);

    // Configuration
    logic                  enabled_reg;
    logic [DURATION_W-1:0] duration_reg;

    // Latched input word
    nos_in_t     in_reg;
    logic [31:0] due_reg;
    logic        drop_reg;

    // Scan counters and fill count
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  w_reg;
    logic [EMIT_W-1:0] n_reg;
    logic [CNT_W-1:0]  i_inc;

    // Held due slot and output register
    nos_slot_t hold_reg;
    logic      hold_valid_reg;
    nos_out_t  out_reg;
    logic      out_valid_reg;
    logic      out_free;
    logic      out_load;
    nos_out_t  out_next;

    // Slot memory ports
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    nos_slot_t        ram_wdata;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    nos_slot_t        ram_rdata;
    logic [SLOT_W-1:0] ram_rbits;

    logic [32:0] due_sum;
    logic [31:0] due_sat;

    assign cfg.ready = 1'b1;

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg  <= DEF_ENABLED;
            duration_reg <= DEF_DURATION;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                REG_ENABLED: enabled_reg  <= cfg.data.value[0];
                REG_SUSTAIN: duration_reg <= cfg.data.value;
                default:     enabled_reg  <= enabled_reg;
            endcase
        end
    end

    // Saturating due time
    assign due_sum = {1'b0, in_word.stamp} + {9'd0, duration_reg};
    assign due_sat = due_sum[32] ? '1 : due_sum[31:0];

    // Latch the input word
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            in_reg  <= in_word;
            due_reg <= due_sat;
        end
    end

    // Track the table-full flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            drop_reg <= 1'b0;
        end
        else if (cmd.set_drop)
        begin
            drop_reg <= 1'b1;
        end
    end

    assign i_inc = i_reg + CNT_W'(1);

    // Advance scan counters and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            i_reg     <= '0;
            w_reg     <= '0;
            n_reg     <= '0;
        end
        else
        begin
            if (cmd.rd_first)
            begin
                i_reg <= '0;
                w_reg <= '0;
                n_reg <= '0;
            end
            else
            begin
                if (cmd.rd_next)
                begin
                    i_reg <= i_inc;
                end
                if (cmd.keep)
                begin
                    w_reg <= w_reg + CNT_W'(1);
                end
                if (cmd.emit)
                begin
                    n_reg <= n_reg + EMIT_W'(1);
                end
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.commit)
            begin
                count_reg <= w_reg;
            end
        end
    end

    // Drive the slot memory
    always_comb
    begin
        ram_we    = cmd.upd | cmd.append | cmd.keep;
        ram_waddr = i_reg[IDX_W-1:0];
        ram_wdata = '{pitch: in_reg.pitch, voice: in_reg.voice, due: due_reg};
        if (cmd.append)
        begin
            ram_waddr = count_reg[IDX_W-1:0];
        end
        else if (cmd.keep)
        begin
            ram_waddr = w_reg[IDX_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    assign ram_re    = cmd.rd_first | cmd.rd_next;
    assign ram_raddr = cmd.rd_first ? '0 : i_inc[IDX_W-1:0];

    nos_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (PENDING_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = nos_slot_t'(ram_rbits);

    // Hold the most recent due slot until the next one or the end of scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (cmd.flush)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            hold_reg <= ram_rdata;
        end
    end

    // Select the output word
    assign out_free = !out_valid_reg || results.ready;
    assign out_load = cmd.send | cmd.flush | (cmd.emit & hold_valid_reg);

    always_comb
    begin
        if (cmd.send)
        begin
            out_next = '{out_pitch: in_reg.pitch, out_velocity: in_reg.velocity,
                         out_voice: in_reg.voice, out_stamp: in_reg.stamp,
                         is_last: 1'b1, dropped: drop_reg};
        end
        else
        begin
            out_next = '{out_pitch: hold_reg.pitch, out_velocity: 7'd0,
                         out_voice: hold_reg.voice, out_stamp: hold_reg.due,
                         is_last: cmd.flush, dropped: 1'b0};
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

    // Report status
    always_comb
    begin
        status.is_tick     = (in_reg.opcode == OP_TICK);
        status.enabled     = enabled_reg;
        status.vel_zero    = (in_reg.velocity == 7'd0);
        status.count_zero  = (count_reg == '0);
        status.full        = (count_reg == CNT_W'(PENDING_DEPTH));
        status.last_slot   = (i_inc == count_reg);
        status.pitch_match = (ram_rdata.pitch == in_reg.pitch);
        status.due_hit     = (ram_rdata.due < in_reg.stamp) && (n_reg < EMIT_W'(MAX_OUT));
        status.hold_valid  = hold_valid_reg;
        status.out_free    = out_free;
    end

    // Fill count stays within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PENDING_DEPTH))
        else $error("fill count beyond table depth");

    // No more than the tick limit is released
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= EMIT_W'(MAX_OUT))
        else $error("too many note-offs released");

    // Output register is never overwritten while full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("output word overwritten");

    // Compaction never writes ahead of the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.keep |-> (w_reg <= i_reg))
        else $error("compaction ahead of scan");

    // A flushed word follows a held slot
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (results.valid && results.data.is_last && !hold_valid_reg))
        else $error("flush lost the last slot");

endmodule
